[src/rgbhsv_pkg.sv]
// ----------------------------------------------------------------------------
// RGB to HSV package
// Shared constants and the control record that travels down the divider row.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int SEL_BITS        = 2;
   localparam int HUE_BITS        = 15;
   localparam int COMP_BITS       = 16;
   // Quotient bits of the hue offset (at most 3840) and of the saturation.
   localparam int HUE_Q_BITS      = 12;
   localparam int SAT_Q_BITS      = 16;
   localparam int CELL_COUNT      = SAT_Q_BITS;

   localparam logic [HUE_BITS-1:0]  HUE_BASE_RED   = 15'd0;
   localparam logic [HUE_BITS-1:0]  HUE_BASE_GREEN = 15'd7680;
   localparam logic [HUE_BITS-1:0]  HUE_BASE_BLUE  = 15'd15360;
   localparam logic [HUE_BITS+1:0]  HUE_FULL       = 17'd23040;
   localparam logic [COMP_BITS-1:0] SAT_ONE        = 16'hFFFF;

   localparam logic [SEL_BITS-1:0] SEL_HUE     = 2'd0;
   localparam logic [SEL_BITS-1:0] SEL_SAT     = 2'd1;
   localparam logic [SEL_BITS-1:0] SEL_VAL     = 2'd2;
   // The spare selector code also picks hue.
   localparam logic [SEL_BITS-1:0] SEL_HUE_ALT = 2'd3;

   typedef struct packed {
      logic                valid;
      logic [SEL_BITS-1:0] sel;
      logic                hue_neg;
      logic                hue_zero;
      logic                sat_full;
      logic                sat_zero;
      logic [HUE_BITS-1:0] hue_base;
   } ctrl_type;

endpackage

[src/rgbhsv_front.sv]
// ----------------------------------------------------------------------------
// RGB to HSV front stage
// Finds the largest and smallest channel, the sector and the divider operands.
// ----------------------------------------------------------------------------
module rgbhsv_front #(
   parameter int SAMPLE_BITS = rgbhsv_pkg::SAMPLE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [SAMPLE_BITS-1:0]       red,
   input  logic [SAMPLE_BITS-1:0]       green,
   input  logic [SAMPLE_BITS-1:0]       blue,
   input  logic [rgbhsv_pkg::SEL_BITS-1:0] sel,
   output rgbhsv_pkg::ctrl_type         ctrl_ff,
   output logic [SAMPLE_BITS-1:0]       hi_ff,
   output logic [SAMPLE_BITS-1:0]       srem_ff,
   output logic [SAMPLE_BITS-1:0]       span_ff,
   output logic [SAMPLE_BITS-1:0]       hrem_ff,
   output logic [rgbhsv_pkg::HUE_Q_BITS-1:0] hnum_ff
);

   localparam int NW = SAMPLE_BITS + rgbhsv_pkg::HUE_Q_BITS;

   logic [SAMPLE_BITS-1:0] hi, lo, span, absd;
   logic [SAMPLE_BITS:0]   diff;
   logic [NW-1:0]          num;
   rgbhsv_pkg::ctrl_type   ctrl_in;

   always_comb begin
      hi = red;
      if (green > hi) hi = green;
      if (blue > hi) hi = blue;
      lo = red;
      if (green < lo) lo = green;
      if (blue < lo) lo = blue;
      span = hi - lo;

      ctrl_in = '0;
      ctrl_in.valid = in_valid;
      ctrl_in.sel   = sel;
      // Ties for the largest channel go to red, then green.
      if (hi == red) begin
         diff = {1'b0, green} - {1'b0, blue};
         ctrl_in.hue_base = rgbhsv_pkg::HUE_BASE_RED;
      end else if (hi == green) begin
         diff = {1'b0, blue} - {1'b0, red};
         ctrl_in.hue_base = rgbhsv_pkg::HUE_BASE_GREEN;
      end else begin
         diff = {1'b0, red} - {1'b0, green};
         ctrl_in.hue_base = rgbhsv_pkg::HUE_BASE_BLUE;
      end
      ctrl_in.hue_neg  = diff[SAMPLE_BITS];
      ctrl_in.hue_zero = (span == '0);
      ctrl_in.sat_zero = (hi == '0);
      ctrl_in.sat_full = (span == hi);
      absd = diff[SAMPLE_BITS] ? SAMPLE_BITS'(-diff) : diff[SAMPLE_BITS-1:0];
      // 3840 * |diff| as (x << 12) - (x << 8).
      num = {absd, 12'd0} - {4'd0, absd, 8'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (en) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hi_ff   <= hi;
         srem_ff <= span;
         span_ff <= span;
         hrem_ff <= num[NW-1:rgbhsv_pkg::HUE_Q_BITS];
         hnum_ff <= num[rgbhsv_pkg::HUE_Q_BITS-1:0];
      end
   end

endmodule

[src/rgbhsv_div_cell.sv]
// ----------------------------------------------------------------------------
// RGB to HSV divider cell
// One restoring step of the saturation division per cell, and of the hue division in the first 12 cells.
// ----------------------------------------------------------------------------
module rgbhsv_div_cell #(
   parameter int SAMPLE_BITS = rgbhsv_pkg::SAMPLE_BITS_DEF,
   parameter int CELL_INDEX  = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  rgbhsv_pkg::ctrl_type                 ctrl_i,
   input  logic [SAMPLE_BITS-1:0]               hi_i,
   input  logic [SAMPLE_BITS-1:0]               srem_i,
   input  logic [rgbhsv_pkg::SAT_Q_BITS-1:0]    sq_i,
   input  logic [SAMPLE_BITS-1:0]               span_i,
   input  logic [SAMPLE_BITS-1:0]               hrem_i,
   input  logic [rgbhsv_pkg::HUE_Q_BITS-1:0]    hnum_i,
   input  logic [rgbhsv_pkg::HUE_Q_BITS-1:0]    hq_i,
   output rgbhsv_pkg::ctrl_type                 ctrl_ff,
   output logic [SAMPLE_BITS-1:0]               hi_ff,
   output logic [SAMPLE_BITS-1:0]               srem_ff,
   output logic [rgbhsv_pkg::SAT_Q_BITS-1:0]    sq_ff,
   output logic [SAMPLE_BITS-1:0]               span_ff,
   output logic [SAMPLE_BITS-1:0]               hrem_ff,
   output logic [rgbhsv_pkg::HUE_Q_BITS-1:0]    hnum_ff,
   output logic [rgbhsv_pkg::HUE_Q_BITS-1:0]    hq_ff
);

   localparam int QH = rgbhsv_pkg::HUE_Q_BITS;
   localparam int QS = rgbhsv_pkg::SAT_Q_BITS;

   logic [SAMPLE_BITS:0]   st, ht;
   logic                   sbit, hbit;
   logic [SAMPLE_BITS-1:0] srem_in, hrem_in;
   logic [QH-1:0]          hnum_in, hq_in;
   logic [QS-1:0]          sq_in;

   always_comb begin
      st      = {srem_i, 1'b0};
      sbit    = (st >= {1'b0, hi_i});
      srem_in = sbit ? SAMPLE_BITS'(st - {1'b0, hi_i}) : st[SAMPLE_BITS-1:0];
      sq_in   = {sq_i[QS-2:0], sbit};

      ht   = {hrem_i, hnum_i[QH-1]};
      hbit = (ht >= {1'b0, span_i});
      // The hue division is shorter; the last cells hand it on unchanged.
      if (CELL_INDEX < QH) begin
         hrem_in = hbit ? SAMPLE_BITS'(ht - {1'b0, span_i}) : ht[SAMPLE_BITS-1:0];
         hnum_in = {hnum_i[QH-2:0], 1'b0};
         hq_in   = {hq_i[QH-2:0], hbit};
      end else begin
         hrem_in = hrem_i;
         hnum_in = hnum_i;
         hq_in   = hq_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (en) begin
         ctrl_ff <= ctrl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hi_ff   <= hi_i;
         srem_ff <= srem_in;
         sq_ff   <= sq_in;
         span_ff <= span_i;
         hrem_ff <= hrem_in;
         hnum_ff <= hnum_in;
         hq_ff   <= hq_in;
      end
   end

endmodule

[src/rgb_to_hsv_converter_core.sv]
// ----------------------------------------------------------------------------
// RGB to HSV converter core
// Converts one RGB sample triple per cycle, unless the output stalls, to hue, saturation and value.
// ----------------------------------------------------------------------------
//  channel  direction  fields
//  req_     in         tdata: red, green, blue; tuser: component_select
//  rsp_     out        tdata: hue, saturation, brightness, selected_component
//
// One transaction is accepted every cycle unless the output stalls. The path
// is a front stage, a row of 16 divider cells (one saturation quotient bit
// each, hue bits in the first 12 only) and an output register. Reset clears
// the control records along the row and the output valid flag.
// A stalled output holds the whole row, so req_tready follows rsp_tready
// whenever the output register is full.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_core #(
   parameter int SAMPLE_BITS = rgbhsv_pkg::SAMPLE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // red [S-1:0], green [2S-1:S], blue [3S-1:2S], zero fill
   input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   // component_select [1:0]
   input  logic [rgbhsv_pkg::SEL_BITS-1:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // hue [14:0], saturation [30:15], brightness [46:31],
   // selected_component [62:47], zero fill [63]
   output logic [63:0] rsp_tdata
);

   localparam int N  = rgbhsv_pkg::CELL_COUNT;
   localparam int QH = rgbhsv_pkg::HUE_Q_BITS;
   localparam int QS = rgbhsv_pkg::SAT_Q_BITS;
   localparam int CB = rgbhsv_pkg::COMP_BITS;

   logic en;

   rgbhsv_pkg::ctrl_type   ctrl [N+1];
   logic [SAMPLE_BITS-1:0] hi   [N+1];
   logic [SAMPLE_BITS-1:0] srem [N+1];
   logic [QS-1:0]          sq   [N+1];
   logic [SAMPLE_BITS-1:0] span [N+1];
   logic [SAMPLE_BITS-1:0] hrem [N+1];
   logic [QH-1:0]          hnum [N+1];
   logic [QH-1:0]          hq   [N+1];

   logic                         out_valid_ff;
   logic [63:0]                  out_data_ff;
   logic [rgbhsv_pkg::HUE_BITS+1:0] hsum;
   logic [rgbhsv_pkg::HUE_BITS-1:0] hue;
   logic [CB-1:0]                sat, bright, pick;
   rgbhsv_pkg::ctrl_type         fin;

   assign en         = !out_valid_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   assign sq[0] = '0;
   assign hq[0] = '0;

   rgbhsv_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_valid(req_tvalid),
      .red     (req_tdata[SAMPLE_BITS-1:0]),
      .green   (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .blue    (req_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
      .sel     (req_tuser),
      .ctrl_ff (ctrl[0]),
      .hi_ff   (hi[0]),
      .srem_ff (srem[0]),
      .span_ff (span[0]),
      .hrem_ff (hrem[0]),
      .hnum_ff (hnum[0])
   );

   for (genvar k = 0; k < N; k++) begin : g_cell
      rgbhsv_div_cell #(.SAMPLE_BITS(SAMPLE_BITS), .CELL_INDEX(k)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .ctrl_i (ctrl[k]),
         .hi_i   (hi[k]),
         .srem_i (srem[k]),
         .sq_i   (sq[k]),
         .span_i (span[k]),
         .hrem_i (hrem[k]),
         .hnum_i (hnum[k]),
         .hq_i   (hq[k]),
         .ctrl_ff(ctrl[k+1]),
         .hi_ff  (hi[k+1]),
         .srem_ff(srem[k+1]),
         .sq_ff  (sq[k+1]),
         .span_ff(span[k+1]),
         .hrem_ff(hrem[k+1]),
         .hnum_ff(hnum[k+1]),
         .hq_ff  (hq[k+1])
      );
   end

   always_comb begin
      fin = ctrl[N];
      // Only the red sector can go below zero; it then wraps by 360 degrees.
      if (fin.hue_neg) begin
         hsum = {2'b00, fin.hue_base} - {5'd0, hq[N]};
      end else begin
         hsum = {2'b00, fin.hue_base} + {5'd0, hq[N]};
      end
      if (fin.hue_zero) begin
         hue = '0;
      end else if (hsum[rgbhsv_pkg::HUE_BITS+1]) begin
         hue = rgbhsv_pkg::HUE_BITS'(hsum + rgbhsv_pkg::HUE_FULL);
      end else begin
         hue = hsum[rgbhsv_pkg::HUE_BITS-1:0];
      end

      if (fin.sat_zero) begin
         sat = '0;
      end else if (fin.sat_full) begin
         sat = rgbhsv_pkg::SAT_ONE;
      end else begin
         sat = sq[N];
      end

      bright = CB'(hi[N]);

      unique case (fin.sel)
         rgbhsv_pkg::SEL_SAT: pick = sat;
         rgbhsv_pkg::SEL_VAL: pick = bright;
         default:             pick = {1'b0, hue};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= fin.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_data_ff <= {1'b0, pick, bright, sat, hue};
      end
   end

endmodule

[tb/tb_rgb_to_hsv_converter_core.sv]
// ----------------------------------------------------------------------------
// RGB to HSV converter core testbench
// Sends directed and random colour samples with random gaps and output stalls,
// and compares each result transaction against a hue, saturation and value
// calculation made here in integer arithmetic.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_converter_core;

   localparam int SB         = rgbhsv_pkg::SAMPLE_BITS_DEF;
   localparam int SLB        = rgbhsv_pkg::SEL_BITS;
   localparam int HB         = rgbhsv_pkg::HUE_BITS;
   localparam int CB         = rgbhsv_pkg::COMP_BITS;
   localparam int DATA_W     = ((3*SB+7)/8)*8;
   localparam int RANDOM_CNT = 1950;

   typedef struct packed {
      logic [HB-1:0] hue;
      logic [CB-1:0] sat;
      logic [CB-1:0] val;
      logic [CB-1:0] pick;
   } hsv_type;

   typedef struct {
      logic [SB-1:0]  r, g, b;
      logic [SLB-1:0] sel;
      logic           known;
      hsv_type        hsv;
   } pixel_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [DATA_W-1:0] req_tdata = '0;
   logic [SLB-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [63:0] rsp_tdata;

   hsv_type pending_hsv[$];
   int errors = 0;
   int results_seen = 0;
   int stall_hold = 0;
   bit stall_quiet = 0;

   rgb_to_hsv_converter_core dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic hsv_type convert_pixel(logic [SB-1:0] r, logic [SB-1:0] g,
                                             logic [SB-1:0] b, logic [SLB-1:0] sel);
      longint hi, lo, span, diff, num, h, sat, base;
      hsv_type res;
      hi = r; lo = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      span = hi - lo;
      sat = 0;
      h = 0;
      if (hi != 0) begin
         sat = (span << 16) / hi;
         if (sat > 65535) sat = 65535;
      end
      if (span != 0) begin
         if (hi == r) begin
            base = rgbhsv_pkg::HUE_BASE_RED; diff = longint'(g) - longint'(b);
         end else if (hi == g) begin
            base = rgbhsv_pkg::HUE_BASE_GREEN; diff = longint'(b) - longint'(r);
         end else begin
            base = rgbhsv_pkg::HUE_BASE_BLUE; diff = longint'(r) - longint'(g);
         end
         num = 3840 * diff;
         // Truncation toward zero on a negative numerator.
         h = (num < 0) ? base - ((-num) / span) : base + num / span;
         if (h < 0) h += rgbhsv_pkg::HUE_FULL;
      end
      res.hue = h[HB-1:0];
      res.sat = sat[15:0];
      res.val = hi[15:0];
      case (sel)
         rgbhsv_pkg::SEL_SAT: res.pick = res.sat;
         rgbhsv_pkg::SEL_VAL: res.pick = res.val;
         default:             res.pick = {1'b0, res.hue};
      endcase
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch on result %0d: %s got %0d, expected %0d",
               results_seen, what, got, want);
      errors++;
   endtask

   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 93) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   task automatic send_pixel(logic [SB-1:0] r, logic [SB-1:0] g, logic [SB-1:0] b,
                             logic [SLB-1:0] sel, bit quiet);
      int gap;
      gap = quiet ? 0 : gap_length();
      // Idle cycles drop tvalid; back-to-back transactions keep it high.
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {{(DATA_W-3*SB){1'b0}}, b, g, r};
      req_tuser  <= sel;
      pending_hsv.push_back(convert_pixel(r, g, b, sel));
      do @(posedge clock); while (!req_tready);
   endtask

   // Result side: random stalls, checks against the oldest expectation.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            hsv_type got, want;
            got.hue  = rsp_tdata[14:0];
            got.sat  = rsp_tdata[30:15];
            got.val  = rsp_tdata[46:31];
            got.pick = rsp_tdata[62:47];
            if (pending_hsv.size() == 0) begin
               report_mismatch("result with nothing outstanding", 1, 0);
            end else begin
               want = pending_hsv.pop_front();
               if (got.hue != want.hue) report_mismatch("hue", got.hue, want.hue);
               if (got.sat != want.sat) report_mismatch("saturation", got.sat, want.sat);
               if (got.val != want.val) report_mismatch("brightness", got.val, want.val);
               if (got.pick != want.pick)
                  report_mismatch("selected_component", got.pick, want.pick);
               if (rsp_tdata[63] !== 1'b0) report_mismatch("fill bit", rsp_tdata[63], 0);
            end
            results_seen++;
         end
         if (stall_quiet) begin
            rsp_tready <= 1;
         end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
            if ($urandom_range(0, 3) == 0) stall_hold <= gap_length();
         end
      end
   end

   initial begin
      pixel_row_type rows[$];
      pixel_row_type row;
      int wait_cycles;
      logic [SB-1:0] top, r, g, b;
      repeat (7) @(posedge clock);
      reset <= 0;
      // Directed table: known expectations where obvious, else predicted.
      rows = '{
         '{16'd0, 16'd0, 16'd0, rgbhsv_pkg::SEL_HUE, 1, '{15'd0, 16'd0, 16'd0, 16'd0}},
         '{16'hFFFF, 16'hFFFF, 16'hFFFF, rgbhsv_pkg::SEL_VAL, 1,
           '{15'd0, 16'd0, 16'hFFFF, 16'hFFFF}},
         '{16'hFFFF, 16'd0, 16'd0, rgbhsv_pkg::SEL_SAT, 1,
           '{15'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF}},
         '{16'd0, 16'hFFFF, 16'd0, rgbhsv_pkg::SEL_HUE, 1,
           '{15'd7680, 16'hFFFF, 16'hFFFF, 16'd7680}},
         '{16'd0, 16'd0, 16'hFFFF, rgbhsv_pkg::SEL_HUE_ALT, 1,
           '{15'd15360, 16'hFFFF, 16'hFFFF, 16'd15360}},
         '{16'hFFFF, 16'd0, 16'hFFFF, rgbhsv_pkg::SEL_HUE, 1,
           '{15'd19200, 16'hFFFF, 16'hFFFF, 16'd19200}},
         '{16'hFFFF, 16'hFFFF, 16'd0, rgbhsv_pkg::SEL_HUE, 1,
           '{15'd3840, 16'hFFFF, 16'hFFFF, 16'd3840}},
         '{16'd0, 16'hFFFF, 16'hFFFF, rgbhsv_pkg::SEL_HUE, 1,
           '{15'd11520, 16'hFFFF, 16'hFFFF, 16'd11520}},
         '{16'd1, 16'd0, 16'd0, rgbhsv_pkg::SEL_VAL, 0, '0},
         '{16'd5, 16'd5, 16'd5, rgbhsv_pkg::SEL_SAT, 0, '0},
         '{16'd100, 16'd0, 16'd1, rgbhsv_pkg::SEL_HUE, 0, '0},
         '{16'd100, 16'd1, 16'd0, rgbhsv_pkg::SEL_HUE_ALT, 0, '0},
         '{16'd0, 16'd100, 16'd1, rgbhsv_pkg::SEL_HUE, 0, '0},
         '{16'd1, 16'd0, 16'd100, rgbhsv_pkg::SEL_HUE, 0, '0},
         '{16'hFFFF, 16'hFFFE, 16'd0, rgbhsv_pkg::SEL_SAT, 0, '0},
         '{16'hFFFF, 16'hFFFE, 16'hFFFD, rgbhsv_pkg::SEL_SAT, 0, '0},
         '{16'h8000, 16'h7FFF, 16'h5555, rgbhsv_pkg::SEL_HUE, 0, '0},
         '{16'h1234, 16'hAAAA, 16'h5555, rgbhsv_pkg::SEL_VAL, 0, '0}
      };
      foreach (rows[i]) begin
         row = rows[i];
         if (row.known && convert_pixel(row.r, row.g, row.b, row.sel) != row.hsv)
            report_mismatch("directed row table", i, i);
         send_pixel(row.r, row.g, row.b, row.sel, 0);
      end
      for (int n = 0; n < RANDOM_CNT; n++) begin
         // Bias towards ties and narrow spans, which steer the sector rule.
         top = SB'($urandom);
         case ($urandom_range(0, 5))
            0: begin r = top; g = top; b = SB'($urandom); end
            1: begin r = SB'($urandom); g = top; b = top; end
            2: begin
               r = top;
               g = top - SB'($urandom_range(0, 3));
               b = top - SB'($urandom_range(0, 3));
            end
            3: begin
               r = SB'($urandom_range(0, 7));
               g = SB'($urandom_range(0, 7));
               b = SB'($urandom_range(0, 7));
            end
            default: begin r = SB'($urandom); g = SB'($urandom); b = SB'($urandom); end
         endcase
         // A burst with no idling on either side now and then.
         stall_quiet = (n % 400) < 60;
         send_pixel(r, g, b, SLB'($urandom_range(0, 3)), stall_quiet && (n % 400) < 59);
      end
      req_tvalid <= 0;
      stall_quiet = 0;
      wait_cycles = 0;
      while (pending_hsv.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (40) @(posedge clock);
      $display("Sent %0d directed and %0d random pixels, %0d results checked.",
               rows.size(), RANDOM_CNT, results_seen);
      if (errors == 0 && pending_hsv.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #10000000;
      $display("Run timed out.");
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
